>>> rtl/core/tsd_pkg.sv
// Package for the TLV stream decoder: parse phases, result and error codes,
// register indexes and the result record. No dependencies.
package tsd_pkg;

    localparam int unsigned CfgDataWidth  = 62;
    localparam int unsigned CfgIndexWidth = 2;

    typedef enum logic [3:0] {
        PH_HTAG1 = 4'd0,
        PH_HTAG2 = 4'd1,
        PH_HLEN  = 4'd2,
        PH_HLENX = 4'd3,
        PH_OTAG1 = 4'd4,
        PH_OTAG2 = 4'd5,
        PH_OLEN  = 4'd6,
        PH_OLENX = 4'd7,
        PH_INT   = 4'd8,
        PH_PAY   = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        RK_HEADER = 3'd0,
        RK_INT    = 3'd1,
        RK_BYTE   = 3'd2,
        RK_EMPTY  = 3'd3,
        RK_ERROR  = 3'd4
    } t_result_kind;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_RANGE     = 2'd1,
        ERR_UNEXPECT  = 2'd2,
        ERR_TRUNCATED = 2'd3
    } t_error_code;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_TAG_MASK = 2'd0,
        REG_KIND_MAP = 2'd1
    } t_reg_index;

    localparam logic [7:0]  TAG_ESCAPE = 8'h7F;
    localparam logic [7:0]  LEN_ONE    = 8'h81;
    localparam logic [7:0]  LEN_TWO    = 8'h82;
    localparam logic [15:0] TAG_LOW    = 16'h0080;
    localparam logic [15:0] TAG_HIGH   = 16'h009E;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [15:0] obj_tag;
        logic [1:0]  obj_kind;
        logic [15:0] obj_length;
        logic [31:0] value_out;
        logic [15:0] byte_index;
        logic        last_of_object;
        logic [1:0]  error_code;
        logic        message_end;
    } t_result;

endpackage

>>> rtl/core/tsd_if.sv
// Channel interfaces for the TLV stream decoder: input bytes, results and
// register writes. Depends on tsd_pkg.
interface tsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       final_byte;

    modport source (output valid, output in_byte, output final_byte, input ready);
    modport sink (input valid, input in_byte, input final_byte, output ready);
endinterface

interface tsd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic [15:0] obj_tag;
    logic [1:0]  obj_kind;
    logic [15:0] obj_length;
    logic [31:0] value_out;
    logic [15:0] byte_index;
    logic        last_of_object;
    logic [1:0]  error_code;
    logic        message_end;

    modport source (
        output valid, output result_kind, output obj_tag, output obj_kind,
        output obj_length, output value_out, output byte_index,
        output last_of_object, output error_code, output message_end,
        input ready
    );
    modport sink (
        input valid, input result_kind, input obj_tag, input obj_kind,
        input obj_length, input value_out, input byte_index,
        input last_of_object, input error_code, input message_end,
        output ready
    );
endinterface

interface tsd_cfg_if;
    import tsd_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CfgIndexWidth-1:0] index;
    logic [CfgDataWidth-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/tlv_stream_decoder.sv
// Top level of the TLV stream decoder: input byte register, parse state and
// result register in one module. Depends on tsd_pkg and the channel interfaces.
// Each byte is registered at input; its result is registered at the output.
// Throughput: one byte per cycle; the parse state updates in a single pass
// through the byte register, held only while a result waits at the output.
// Reset (synchronous, active low) clears config, valid flags and parse state.
module tlv_stream_decoder
    import tsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    tsd_in_if.sink      i_in,
    tsd_cfg_if.sink     i_cfg,
    tsd_out_if.source   o_out
);

    logic [30:0] r_tag_mask;
    logic [61:0] r_kind_map;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_final;

    t_phase      r_phase, n_phase;
    logic [15:0] r_tag, n_tag;
    logic [15:0] r_length, n_length;
    logic [1:0]  r_left, n_left;
    logic [31:0] r_acc, n_acc;
    logic [15:0] r_count, n_count;
    logic        r_err_hold, n_err_hold;

    logic        r_out_valid;
    t_result     r_out;

    t_result     res;
    logic        have_res;
    logic        len_done;
    logic        proc_en;
    logic [15:0] count_inc;
    logic        tag_ok;
    logic [4:0]  slot;
    logic [1:0]  tag_kind;

    function automatic t_result make_res(
        input t_result_kind kind, input logic [15:0] tag, input logic [1:0] okind,
        input logic [15:0] len, input logic [31:0] val, input logic [15:0] idx,
        input logic last, input t_error_code err
    );
        t_result r;
        r.result_kind    = kind;
        r.obj_tag        = tag;
        r.obj_kind       = okind;
        r.obj_length     = len;
        r.value_out      = val;
        r.byte_index     = idx;
        r.last_of_object = last;
        r.error_code     = err;
        r.message_end    = 1'b0;
        return r;
    endfunction

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_mask <= '0;
            r_kind_map <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_TAG_MASK: r_tag_mask <= i_cfg.data[30:0];
                REG_KIND_MAP: r_kind_map <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign proc_en    = r_in_valid && (!have_res || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || proc_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte  <= i_in.in_byte;
            r_in_final <= i_in.final_byte;
        end
    end

    assign tag_ok   = (r_tag >= TAG_LOW) && (r_tag <= TAG_HIGH);
    assign slot     = r_tag[4:0];
    assign tag_kind = tag_ok ? r_kind_map[{slot, 1'b0} +: 2] : 2'd0;
    assign count_inc = r_count + 16'd1;

    always_comb begin
        n_phase    = r_phase;
        n_tag      = r_tag;
        n_length   = r_length;
        n_left     = r_left;
        n_acc      = r_acc;
        n_count    = r_count;
        n_err_hold = r_err_hold;
        have_res   = 1'b0;
        len_done   = 1'b0;
        res        = make_res(RK_HEADER, 16'd0, 2'd0, 16'd0, 32'd0, 16'd0, 1'b0,
                              ERR_NONE);

        if (!r_err_hold) begin
            case (r_phase)
                PH_HTAG1, PH_OTAG1: begin
                    if (r_in_byte == TAG_ESCAPE) begin
                        n_tag   = {TAG_ESCAPE, 8'h00};
                        n_phase = (r_phase == PH_HTAG1) ? PH_HTAG2 : PH_OTAG2;
                    end else begin
                        n_tag = {8'h00, r_in_byte};
                        if (r_phase == PH_HTAG1) begin
                            have_res = 1'b1;
                            res = make_res(RK_HEADER, n_tag, 2'd0, 16'd0, 32'd0,
                                           16'd0, 1'b0, ERR_NONE);
                        end
                        n_phase = (r_phase == PH_HTAG1) ? PH_HLEN : PH_OLEN;
                    end
                end
                PH_HTAG2: begin
                    n_tag    = {TAG_ESCAPE, r_in_byte};
                    have_res = 1'b1;
                    res = make_res(RK_HEADER, n_tag, 2'd0, 16'd0, 32'd0, 16'd0,
                                   1'b0, ERR_NONE);
                    n_phase  = PH_HLEN;
                end
                PH_OTAG2: begin
                    n_tag   = {TAG_ESCAPE, r_in_byte};
                    n_phase = PH_OLEN;
                end
                PH_HLEN: begin
                    if (r_in_byte == LEN_ONE || r_in_byte == LEN_TWO) begin
                        n_left  = r_in_byte[1:0];
                        n_phase = PH_HLENX;
                    end else begin
                        n_phase = PH_OTAG1;
                    end
                end
                PH_HLENX: begin
                    n_left = r_left - 2'd1;
                    if (n_left == 2'd0) begin
                        n_phase = PH_OTAG1;
                    end
                end
                PH_OLEN: begin
                    if (r_in_byte == LEN_ONE || r_in_byte == LEN_TWO) begin
                        n_length = 16'd0;
                        n_left   = r_in_byte[1:0];
                        n_phase  = PH_OLENX;
                    end else begin
                        n_length = {8'h00, r_in_byte};
                        len_done = 1'b1;
                    end
                end
                PH_OLENX: begin
                    n_length = {r_length[7:0], r_in_byte};
                    n_left   = r_left - 2'd1;
                    len_done = (n_left == 2'd0);
                end
                PH_INT: begin
                    n_acc   = {r_acc[23:0], r_in_byte};
                    n_count = count_inc;
                    if (count_inc >= r_length) begin
                        have_res = 1'b1;
                        res = make_res(RK_INT, r_tag, tag_kind, r_length, n_acc,
                                       16'd0, 1'b1, ERR_NONE);
                        n_phase  = PH_OTAG1;
                    end
                end
                PH_PAY: begin
                    n_count  = count_inc;
                    have_res = 1'b1;
                    res = make_res(RK_BYTE, r_tag, tag_kind, r_length,
                                   {24'd0, r_in_byte}, r_count,
                                   count_inc >= r_length, ERR_NONE);
                    if (count_inc >= r_length) begin
                        n_phase = PH_OTAG1;
                    end
                end
                default: begin
                    n_phase = PH_OTAG1;
                end
            endcase

            if (len_done) begin
                if (!tag_ok) begin
                    have_res   = 1'b1;
                    res = make_res(RK_ERROR, r_tag, 2'd0, n_length, 32'd0, 16'd0,
                                   1'b0, ERR_RANGE);
                    n_err_hold = 1'b1;
                end else if (!r_tag_mask[slot]) begin
                    have_res   = 1'b1;
                    res = make_res(RK_ERROR, r_tag, 2'd0, n_length, 32'd0, 16'd0,
                                   1'b0, ERR_UNEXPECT);
                    n_err_hold = 1'b1;
                end else begin
                    n_count = 16'd0;
                    n_acc   = 32'd0;
                    if (!tag_kind[1]) begin
                        if (n_length >= 16'd1 && n_length <= 16'd5) begin
                            n_phase = PH_INT;
                        end else begin
                            have_res = 1'b1;
                            res = make_res(RK_INT, r_tag, tag_kind, n_length, 32'd0,
                                           16'd0, 1'b1, ERR_NONE);
                            n_phase  = PH_OTAG1;
                        end
                    end else if (n_length == 16'd0) begin
                        have_res = 1'b1;
                        res = make_res(RK_EMPTY, r_tag, tag_kind, 16'd0, 32'd0,
                                       16'd0, 1'b1, ERR_NONE);
                        n_phase  = PH_OTAG1;
                    end else begin
                        n_phase = PH_PAY;
                    end
                end
            end
        end

        if (r_in_final) begin
            if (!n_err_hold && n_phase != PH_OTAG1) begin
                have_res = 1'b1;
                res = make_res(RK_ERROR, n_tag, 2'd0, n_length, 32'd0, 16'd0,
                               1'b0, ERR_TRUNCATED);
            end
            res.message_end = have_res;
            n_phase    = PH_HTAG1;
            n_tag      = 16'd0;
            n_length   = 16'd0;
            n_left     = 2'd0;
            n_acc      = 32'd0;
            n_count    = 16'd0;
            n_err_hold = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HTAG1;
            r_tag      <= '0;
            r_length   <= '0;
            r_left     <= '0;
            r_acc      <= '0;
            r_count    <= '0;
            r_err_hold <= 1'b0;
        end else if (proc_en) begin
            r_phase    <= n_phase;
            r_tag      <= n_tag;
            r_length   <= n_length;
            r_left     <= n_left;
            r_acc      <= n_acc;
            r_count    <= n_count;
            r_err_hold <= n_err_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_en && have_res) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_en && have_res) begin
            r_out <= res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.result_kind    = r_out.result_kind;
    assign o_out.obj_tag        = r_out.obj_tag;
    assign o_out.obj_kind       = r_out.obj_kind;
    assign o_out.obj_length     = r_out.obj_length;
    assign o_out.value_out      = r_out.value_out;
    assign o_out.byte_index     = r_out.byte_index;
    assign o_out.last_of_object = r_out.last_of_object;
    assign o_out.error_code     = r_out.error_code;
    assign o_out.message_end    = r_out.message_end;

endmodule
